// ===== hw/rtl/fpcp_pkg.sv =====
`timescale 1ns / 1ps

package fpcp_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned WINDOW_W = 16;
  localparam int unsigned HOST_W   = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned NUM_W    = 8;
  localparam int unsigned NUM_CNT  = 6;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned PROG_W   = 3;

  // keyword progress codes
  localparam logic [PROG_W-1:0] PROG_IDLE  = 3'd0;
  localparam logic [PROG_W-1:0] PROG_FIRST = 3'd1;
  localparam logic [PROG_W-1:0] PROG_ARGS  = 3'd5;

  localparam logic [IDX_W-1:0] IDX_LAST = 3'd5;

  localparam logic [DATA_W-1:0] CHR_P_UP  = 8'h50;
  localparam logic [DATA_W-1:0] CHR_P_LO  = 8'h70;
  localparam logic [DATA_W-1:0] CHR_O_UP  = 8'h4F;
  localparam logic [DATA_W-1:0] CHR_O_LO  = 8'h6F;
  localparam logic [DATA_W-1:0] CHR_R_UP  = 8'h52;
  localparam logic [DATA_W-1:0] CHR_R_LO  = 8'h72;
  localparam logic [DATA_W-1:0] CHR_T_UP  = 8'h54;
  localparam logic [DATA_W-1:0] CHR_T_LO  = 8'h74;
  localparam logic [DATA_W-1:0] CHR_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CHR_COMMA = 8'h2C;
  localparam logic [DATA_W-1:0] CHR_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] CHR_LF    = 8'h0A;
  localparam logic [DATA_W-1:0] CHR_ZERO  = 8'h30;
  localparam logic [DATA_W-1:0] CHR_NINE  = 8'h39;

  typedef struct packed {
    logic [DATA_W-1:0]   data_byte;
    logic                first_byte;
    logic                last_byte;
    logic [WINDOW_W-1:0] match_window;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [HOST_W-1:0]   host_address;
    logic [PORT_W-1:0]   data_port;
    logic [OFFSET_W-1:0] arg_offset;
    logic [OFFSET_W-1:0] arg_length;
  } result_t;

  // expected keyword character at a given progress (1..4)
  function automatic logic [DATA_W-1:0] kw_char(input logic [PROG_W-1:0] prog,
                                                input logic lower);
    logic [DATA_W-1:0] c;
    case (prog)
      3'd1:    c = lower ? CHR_O_LO : CHR_O_UP;
      3'd2:    c = lower ? CHR_R_LO : CHR_R_UP;
      3'd3:    c = lower ? CHR_T_LO : CHR_T_UP;
      3'd4:    c = CHR_SPACE;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/fpcp_in_if.sv =====
`timescale 1ns / 1ps

interface fpcp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [15:0] match_window;

  modport source (output valid, output data_byte, output first_byte,
                  output last_byte, output match_window, input ready);
  modport sink   (input valid, input data_byte, input first_byte,
                  input last_byte, input match_window, output ready);
endinterface

// ===== hw/rtl/fpcp_out_if.sv =====
`timescale 1ns / 1ps

interface fpcp_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] host_address;
  logic [15:0] data_port;
  logic [15:0] arg_offset;
  logic [15:0] arg_length;

  modport source (output valid, output found, output host_address, output data_port,
                  output arg_offset, output arg_length, input ready);
  modport sink   (input valid, input found, input host_address, input data_port,
                  input arg_offset, input arg_length, output ready);
endinterface

// ===== hw/rtl/fpcp_in_reg.sv =====
`timescale 1ns / 1ps

module fpcp_in_reg import fpcp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     item_valid,
  output in_item_t item,
  input  logic     item_take
);

  logic     valid_r;
  in_item_t item_r;

  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== hw/rtl/fpcp_scanner.sv =====
`timescale 1ns / 1ps

module fpcp_scanner import fpcp_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_item_t item,
  input  logic     step,
  output logic     res_valid,
  output result_t  res
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [PROG_W-1:0]        prog_r, prog_nxt, prog_base;
  logic                     lower_r, lower_nxt, lower_base;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [WINDOW_W-1:0]      win_r, win_nxt;
  logic [NUM_W-1:0]         nums_r [NUM_CNT];
  logic [NUM_W-1:0]         nums_nxt [NUM_CNT];
  logic [NUM_W-1:0]         nums_base [NUM_CNT];
  logic [IDX_W-1:0]         idx_r, idx_nxt, idx_base;
  logic [POSITION_BITS-1:0] astart_r, astart_nxt, astart_base;
  logic                     done_r, done_nxt, done_base;

  logic [DATA_W-1:0]        b;
  logic                     start_hit;
  logic                     is_digit;
  logic                     is_crlf;
  logic                     success;
  logic [POSITION_BITS-1:0] arg_len;
  logic [POSITION_BITS-1:0] pos_inc;

  assign b        = item.data_byte;
  assign is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
  assign is_crlf  = (b == CHR_CR) || (b == CHR_LF);

  always_comb begin
    // per-packet restart on the first byte, saturating position otherwise
    pos_inc = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
    if (item.first_byte) begin
      pos_nxt     = '0;
      win_nxt     = item.match_window;
      prog_base   = PROG_IDLE;
      lower_base  = 1'b0;
      idx_base    = '0;
      astart_base = '0;
      done_base   = 1'b0;
      for (int i = 0; i < NUM_CNT; i++) nums_base[i] = '0;
    end else begin
      pos_nxt     = pos_inc;
      win_nxt     = win_r;
      prog_base   = prog_r;
      lower_base  = lower_r;
      idx_base    = idx_r;
      astart_base = astart_r;
      done_base   = done_r;
      for (int i = 0; i < NUM_CNT; i++) nums_base[i] = nums_r[i];
    end
  end

  assign start_hit = (WINDOW_W'(pos_nxt) < win_nxt) && ((b == CHR_P_UP) || (b == CHR_P_LO));
  assign arg_len   = (pos_nxt >= astart_base) ? pos_nxt - astart_base : '0;

  always_comb begin
    prog_nxt   = prog_base;
    lower_nxt  = lower_base;
    idx_nxt    = idx_base;
    astart_nxt = astart_base;
    done_nxt   = done_base;
    for (int i = 0; i < NUM_CNT; i++) nums_nxt[i] = nums_base[i];
    success   = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    if (!done_base) begin
      if (prog_base >= PROG_ARGS) begin
        if (is_digit) begin
          nums_nxt[idx_base] = NUM_W'(nums_base[idx_base] * 8'd10 + (b - CHR_ZERO));
        end else if ((b == CHR_COMMA) && (idx_base < IDX_LAST)) begin
          idx_nxt = idx_base + 1'b1;
        end else if (is_crlf && (idx_base == IDX_LAST)) begin
          success = 1'b1;
        end else begin
          prog_nxt = start_hit ? PROG_FIRST : PROG_IDLE;
          if (start_hit) lower_nxt = (b == CHR_P_LO);
        end
      end else if (prog_base != PROG_IDLE) begin
        if (b == kw_char(prog_base, lower_base)) begin
          prog_nxt = prog_base + 1'b1;
          if (prog_nxt == PROG_ARGS) begin
            // argument text starts right after the space
            astart_nxt = (pos_nxt == POS_MAX) ? pos_nxt : pos_nxt + 1'b1;
            idx_nxt    = '0;
            for (int i = 0; i < NUM_CNT; i++) nums_nxt[i] = '0;
          end
        end else begin
          prog_nxt = start_hit ? PROG_FIRST : PROG_IDLE;
          if (start_hit) lower_nxt = (b == CHR_P_LO);
        end
      end else begin
        prog_nxt = start_hit ? PROG_FIRST : PROG_IDLE;
        if (start_hit) lower_nxt = (b == CHR_P_LO);
      end

      if (success) begin
        res_valid        = 1'b1;
        res.found        = 1'b1;
        res.host_address = {nums_base[0], nums_base[1], nums_base[2], nums_base[3]};
        res.data_port    = {nums_base[4], nums_base[5]};
        res.arg_offset   = OFFSET_W'(astart_base);
        res.arg_length   = OFFSET_W'(arg_len);
        done_nxt         = 1'b1;
        prog_nxt         = PROG_IDLE;
      end else if (item.last_byte) begin
        res_valid = 1'b1;
        done_nxt  = 1'b1;
        prog_nxt  = PROG_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_r   <= PROG_IDLE;
      lower_r  <= 1'b0;
      pos_r    <= '0;
      win_r    <= '0;
      idx_r    <= '0;
      astart_r <= '0;
      done_r   <= 1'b0;
      for (int i = 0; i < NUM_CNT; i++) nums_r[i] <= '0;
    end else if (step) begin
      prog_r   <= prog_nxt;
      lower_r  <= lower_nxt;
      pos_r    <= pos_nxt;
      win_r    <= win_nxt;
      idx_r    <= idx_nxt;
      astart_r <= astart_nxt;
      done_r   <= done_nxt;
      for (int i = 0; i < NUM_CNT; i++) nums_r[i] <= nums_nxt[i];
    end
  end

endmodule

// ===== hw/rtl/ftp_port_command_parser_core.sv =====
`timescale 1ns / 1ps
// path: a taken byte passes the input register, then its result is registered onto out_ch
// throughput: one payload byte per cycle; the input register holds a byte only while
//   a result waits on out_ch and that byte also causes a result
// reset: synchronous active-low rst_n clears the scan state, position, window and
//   both valid flags; no clearing pass is needed

module ftp_port_command_parser_core import fpcp_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input logic            clk,
  input logic            rst_n,
  fpcp_in_if.sink        in_ch,
  fpcp_out_if.source     out_ch
);

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     item_take;
  logic     res_valid;
  result_t  res;
  logic     step;

  logic     out_valid_r;
  result_t  out_r;

  assign in_item.data_byte    = in_ch.data_byte;
  assign in_item.first_byte   = in_ch.first_byte;
  assign in_item.last_byte    = in_ch.last_byte;
  assign in_item.match_window = in_ch.match_window;

  fpcp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  fpcp_scanner #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scanner (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .step      (step),
    .res_valid (res_valid),
    .res       (res)
  );

  // a byte with no result never waits on the output side
  assign item_take = !res_valid || !out_valid_r || out_ch.ready;
  assign step      = item_valid && item_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_r.found;
  assign out_ch.host_address = out_r.host_address;
  assign out_ch.data_port    = out_r.data_port;
  assign out_ch.arg_offset   = out_r.arg_offset;
  assign out_ch.arg_length   = out_r.arg_length;

endmodule

// ===== hw/rtl/fpcp_checker.sv =====
`timescale 1ns / 1ps

module fpcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic [31:0] host_address,
  input logic [15:0] data_port,
  input logic [15:0] arg_offset,
  input logic [15:0] arg_length
);

  // a pending result stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // packet end without a command reports all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> (host_address == 32'd0) && (data_port == 16'd0) &&
                            (arg_offset == 16'd0) && (arg_length == 16'd0))
    else $error("miss result carries nonzero fields");

  // a fresh result needs a request taken at the input before it
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching request");

endmodule

bind ftp_port_command_parser_core fpcp_checker u_fpcp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .found        (out_ch.found),
  .host_address (out_ch.host_address),
  .data_port    (out_ch.data_port),
  .arg_offset   (out_ch.arg_offset),
  .arg_length   (out_ch.arg_length)
);

// ===== tb/ftp_port_command_parser_core_tb.sv =====
`timescale 1ns / 1ps

module ftp_port_command_parser_core_tb;
  import fpcp_pkg::*;

  localparam int unsigned POS_BITS       = 16;
  localparam logic [15:0] POS_MAX        = 16'((32'd1 << POS_BITS) - 1);
  localparam int unsigned RANDOM_BYTES   = 650;
  localparam int unsigned STALL_CYCLES   = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam result_t     NO_CMD         = '0;

  typedef struct {
    logic [7:0]  data;
    bit          first;
    bit          last;
    logic [15:0] win;
    bit          typed;
    result_t     want;
  } stim_row_t;

  stim_row_t directed_rows [17] = '{
    // before any packet start the window is zero
    '{CHR_P_UP,  1'b0, 1'b1, 16'hFFFF, 1'b1, NO_CMD},
    // empty numbers count as zero, window just wide enough
    '{CHR_P_UP,  1'b1, 1'b0, 16'd1,    1'b0, NO_CMD},
    '{CHR_O_UP,  1'b0, 1'b0, 16'h0000, 1'b0, NO_CMD},
    '{CHR_R_UP,  1'b0, 1'b0, 16'hFFFF, 1'b0, NO_CMD},
    '{CHR_T_UP,  1'b0, 1'b0, 16'h0000, 1'b0, NO_CMD},
    '{CHR_SPACE, 1'b0, 1'b0, 16'hFFFF, 1'b0, NO_CMD},
    '{CHR_COMMA, 1'b0, 1'b0, 16'h0000, 1'b0, NO_CMD},
    '{CHR_COMMA, 1'b0, 1'b0, 16'hFFFF, 1'b0, NO_CMD},
    '{CHR_COMMA, 1'b0, 1'b0, 16'h0000, 1'b0, NO_CMD},
    '{CHR_COMMA, 1'b0, 1'b0, 16'hFFFF, 1'b0, NO_CMD},
    '{CHR_COMMA, 1'b0, 1'b0, 16'h0000, 1'b0, NO_CMD},
    '{CHR_CR,    1'b0, 1'b0, 16'hFFFF, 1'b1, '{1'b1, 32'h0, 16'h0, 16'd5, 16'd5}},
    // ignored once the packet has reported
    '{8'hFF,     1'b0, 1'b1, 16'hFFFF, 1'b0, NO_CMD},
    // mixed case keyword
    '{CHR_P_LO,  1'b1, 1'b0, 16'hFFFF, 1'b0, NO_CMD},
    '{CHR_O_UP,  1'b0, 1'b1, 16'h0000, 1'b1, NO_CMD},
    // zero window blocks a start at position zero
    '{CHR_P_LO,  1'b1, 1'b1, 16'h0000, 1'b1, NO_CMD},
    '{8'h00,     1'b1, 1'b1, 16'hFFFF, 1'b1, NO_CMD}
  };

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  fpcp_in_if  in_ch ();
  fpcp_out_if out_ch ();

  ftp_port_command_parser_core #(
    .POSITION_BITS(POS_BITS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // scanner state mirrored from the block
  logic [PROG_W-1:0] scan_progress  = PROG_IDLE;
  logic              scan_lower     = 1'b0;
  logic [15:0]       scan_pos       = '0;
  logic [15:0]       scan_window    = '0;
  logic [15:0]       scan_arg_start = '0;
  logic [7:0]        scan_num [NUM_CNT] = '{default: '0};
  logic [IDX_W-1:0]  scan_idx       = '0;
  logic              scan_done      = 1'b0;

  result_t     expected_reports [$];
  int unsigned mismatches      = 0;
  int unsigned bytes_sent      = 0;
  int unsigned random_bytes    = 0;
  int unsigned reports_checked = 0;
  int unsigned commands_seen   = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned stall_count     = 0;
  int unsigned quiet_cycles    = 0;
  bit          stall_request   = 1'b0;
  bit          stall_done      = 1'b0;

  function automatic logic [7:0] keyword_byte(input int k, input bit lower);
    logic [7:0] c;
    case (k)
      0:       c = lower ? CHR_P_LO : CHR_P_UP;
      1:       c = lower ? CHR_O_LO : CHR_O_UP;
      2:       c = lower ? CHR_R_LO : CHR_R_UP;
      3:       c = lower ? CHR_T_LO : CHR_T_UP;
      default: c = CHR_SPACE;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] next_pos(input logic [15:0] p);
    return (p >= POS_MAX) ? POS_MAX : p + 16'd1;
  endfunction

  function automatic void try_start(input logic [7:0] b);
    scan_progress = PROG_IDLE;
    if (scan_pos < scan_window) begin
      if (b == CHR_P_UP) begin
        scan_progress = PROG_FIRST;
        scan_lower    = 1'b0;
      end else if (b == CHR_P_LO) begin
        scan_progress = PROG_FIRST;
        scan_lower    = 1'b1;
      end
    end
  endfunction

  // advances the scanner by one byte, returns 1 when the byte ends in a report
  function automatic bit predict_port_byte(input in_item_t it, output result_t rep);
    logic [15:0] prod;
    bit          hit;
    hit = 1'b0;
    rep = '0;
    if (it.first_byte) begin
      scan_pos       = '0;
      scan_window    = it.match_window;
      scan_progress  = PROG_IDLE;
      scan_lower     = 1'b0;
      scan_num       = '{default: '0};
      scan_idx       = '0;
      scan_arg_start = '0;
      scan_done      = 1'b0;
    end else begin
      scan_pos = next_pos(scan_pos);
    end
    if (scan_done) return 1'b0;

    if (scan_progress >= PROG_ARGS) begin
      if (it.data_byte >= CHR_ZERO && it.data_byte <= CHR_NINE) begin
        prod = 16'(scan_num[scan_idx]) * 16'd10 + 16'(it.data_byte - CHR_ZERO);
        scan_num[scan_idx] = prod[7:0];
      end else if (it.data_byte == CHR_COMMA && scan_idx < IDX_LAST) begin
        scan_idx = scan_idx + 1'b1;
      end else if ((it.data_byte == CHR_CR || it.data_byte == CHR_LF) &&
                   scan_idx == IDX_LAST) begin
        hit = 1'b1;
      end else begin
        try_start(it.data_byte);
      end
    end else if (scan_progress != PROG_IDLE) begin
      if (it.data_byte == keyword_byte(scan_progress, scan_lower)) begin
        scan_progress = scan_progress + 1'b1;
        if (scan_progress == PROG_ARGS) begin
          scan_arg_start = next_pos(scan_pos);
          scan_num       = '{default: '0};
          scan_idx       = '0;
        end
      end else begin
        try_start(it.data_byte);
      end
    end else begin
      try_start(it.data_byte);
    end

    if (hit) begin
      rep.found        = 1'b1;
      rep.host_address = {scan_num[0], scan_num[1], scan_num[2], scan_num[3]};
      rep.data_port    = {scan_num[4], scan_num[5]};
      rep.arg_offset   = scan_arg_start;
      rep.arg_length   = (scan_pos >= scan_arg_start) ? scan_pos - scan_arg_start : '0;
    end
    if (hit || it.last_byte) begin
      scan_done     = 1'b1;
      scan_progress = PROG_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // mostly command characters, the rest any byte
  function automatic logic [7:0] noise_byte();
    logic [7:0] c;
    if ($urandom_range(9) < 4) return 8'($urandom);
    case ($urandom_range(13))
      0:       c = CHR_P_UP;
      1:       c = CHR_P_LO;
      2:       c = CHR_O_UP;
      3:       c = CHR_O_LO;
      4:       c = CHR_R_UP;
      5:       c = CHR_R_LO;
      6:       c = CHR_T_UP;
      7:       c = CHR_T_LO;
      8:       c = CHR_SPACE;
      9:       c = CHR_COMMA;
      10:      c = CHR_CR;
      11:      c = CHR_LF;
      12:      c = CHR_ZERO;
      default: c = CHR_NINE;
    endcase
    return c;
  endfunction

  function automatic void append_command(ref logic [7:0] pkt [$], input bit lower);
    for (int k = 0; k < 5; k++) pkt.push_back(keyword_byte(k, lower));
    for (int n = 0; n < NUM_CNT; n++) begin
      repeat ($urandom_range(4)) pkt.push_back(CHR_ZERO + 8'($urandom_range(9)));
      if (n < NUM_CNT - 1) pkt.push_back(CHR_COMMA);
    end
    pkt.push_back($urandom_range(1) ? CHR_CR : CHR_LF);
  endfunction

  // called just after a falling edge, returns just after a falling edge once the byte has been taken
  task automatic offer_byte(input logic [7:0] b, input bit first, input bit last,
                            input logic [15:0] win, input bit typed,
                            input result_t typed_rep);
    in_item_t it;
    result_t  rep;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.first_byte   <= first;
    in_ch.last_byte    <= last;
    in_ch.match_window <= win;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    it.data_byte    = b;
    it.first_byte   = first;
    it.last_byte    = last;
    it.match_window = win;
    if (predict_port_byte(it, rep) && !typed) expected_reports.push_back(rep);
    if (typed) expected_reports.push_back(typed_rep);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet(input logic [7:0] pkt [$], input logic [15:0] win,
                             input bit close);
    foreach (pkt[i])
      offer_byte(pkt[i], i == 0, close && i == pkt.size() - 1,
                 (i == 0) ? win : 16'($urandom), 1'b0, NO_CMD);
  endtask

  task automatic random_packet();
    logic [7:0]  pkt [$];
    logic [15:0] win;
    int unsigned kind;
    int unsigned lead;
    int unsigned term;
    int unsigned pick;
    bit          close;
    kind = $urandom_range(99);
    lead = $urandom_range(6);
    repeat (lead) pkt.push_back(noise_byte());
    if (kind < 90) begin
      append_command(pkt, 1'($urandom_range(1)));
      term = pkt.size() - 1;
      if (kind >= 60) begin
        pick = $urandom_range(lead, term - 1);
        case ($urandom_range(4))
          0:       pkt = pkt[0:pick];
          1:       pkt[pick] = noise_byte();
          2:       pkt.insert(pick, noise_byte());
          3:       pkt[lead + $urandom_range(1, 3)] ^= 8'h20;
          // comma after the sixth number
          default: pkt.insert(term, CHR_COMMA);
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 12)) pkt.push_back(noise_byte());
    end
    repeat ($urandom_range(3)) pkt.push_back(noise_byte());

    // window edges mostly sit around the keyword start, with zero, full and random windows too
    case ($urandom_range(9))
      0:       win = '0;
      1:       win = 16'(lead);
      2:       win = 16'(lead + 1);
      3:       win = 16'hFFFF;
      4:       win = 16'($urandom);
      default: win = 16'(lead + 1 + $urandom_range(20));
    endcase
    close = ($urandom_range(19) != 0);
    send_packet(pkt, win, close);
    random_bytes += pkt.size();

    // stray bytes with no first byte
    if ($urandom_range(4) == 0)
      repeat ($urandom_range(1, 3))
        offer_byte(noise_byte(), 1'b0, 1'($urandom_range(1)), 16'($urandom), 1'b0, NO_CMD);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_request && !stall_done) begin
      out_ch.ready <= 1'b0;
      stall_count++;
      if (stall_count == STALL_CYCLES) stall_done = 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $error("report with no request pending: found=%0b host=0x%08h port=0x%04h",
               out_ch.found, out_ch.host_address, out_ch.data_port);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("found", want.found, out_ch.found);
        check_field("host_address", want.host_address, out_ch.host_address);
        check_field("data_port", want.data_port, out_ch.data_port);
        check_field("arg_offset", want.arg_offset, out_ch.arg_offset);
        check_field("arg_length", want.arg_length, out_ch.arg_length);
        reports_checked++;
        if (want.found) commands_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.first_byte   = 1'b0;
    in_ch.last_byte    = 1'b0;
    in_ch.match_window = '0;
    rst_n              = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r])
      offer_byte(directed_rows[r].data, directed_rows[r].first, directed_rows[r].last,
                 directed_rows[r].win, directed_rows[r].typed, directed_rows[r].want);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (ph == 2) begin
        // one-byte packets each report, so a held output backs up the input
        stall_request = 1'b1;
        repeat (40) offer_byte(noise_byte(), 1'b1, 1'b1, 16'($urandom), 1'b0, NO_CMD);
        wait (stall_done);
      end
      while (random_bytes < RANDOM_BYTES * (ph + 1) / 3) random_packet();
    end
    in_ch.valid <= 1'b0;

    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d payload bytes sent, %0d reports checked, %0d with a command found",
             bytes_sent, reports_checked, commands_seen);
    $display("covered both stall mixes, back to back traffic and a %0d-cycle output hold",
             STALL_CYCLES);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fpcp_pkg.sv
hw/rtl/fpcp_in_if.sv
hw/rtl/fpcp_out_if.sv
hw/rtl/fpcp_in_reg.sv
hw/rtl/fpcp_scanner.sv
hw/rtl/ftp_port_command_parser_core.sv
hw/rtl/fpcp_checker.sv
tb/ftp_port_command_parser_core_tb.sv
